// ===== hw/rtl/bsle_pkg.sv =====
// shared constants and codes for the bounded sequence list engine
package bsle_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 4;
    localparam int STATUS_W      = 2;

    localparam logic [FUNC_W-1:0] FN_INS_FRONT  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INS_END    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_DEL_FIRST  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_SECOND = 4'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_LAST   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_MID    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_SWAP_FL    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_SWAP_FS    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SWAP_FBL   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_SEARCH     = 4'd9;
    localparam logic [FUNC_W-1:0] FN_ROTATE     = 4'd10;
    localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 4'd11;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd12;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

// ===== hw/rtl/bsle_ram.sv =====
// generic single write port, single read port ram with registered read
module bsle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bounded_sequence_list_engine_top.sv =====
// top level of the bounded sequence list engine
//
// keeps an ordered sequence of up to DEPTH signed 32-bit values as a ring in
// one ram, starting at a head pointer, with a length register
// input channel: func, value, anchor_value with in_valid / in_ready
// output channel: status, found, length with out_valid / out_ready, one
// result item for every input item
// one small sequencer drives the single ram read port and write port; every
// element access is one ram access, so each function takes these steps:
//   inserts at either end, first/last delete, clear, unused codes: no ram read
//   delete second, rotate: read the head, then copy it to its new place
//   swaps: read the head and the partner, then write both back
//   search: read from the head on, ending early on a hit
//   delete middle: pull the elements after the middle one step toward the head
//   insert before: scan for the anchor, push the tail one step back, insert
// one item is in work at a time; in_ready is low while the sequencer is busy
// the result sits in an output register; a new item may be taken in the same
// cycle that the waiting result is taken, never earlier
// reset clears the length, the head pointer and the output valid; the ram is
// not cleared, since only entries holding elements are ever used
module bounded_sequence_list_engine_top #(
    parameter int DEPTH = bsle_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bsle_pkg::FUNC_W-1:0]       func,
    input  logic signed [bsle_pkg::DATA_W-1:0] value,
    input  logic signed [bsle_pkg::DATA_W-1:0] anchor_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bsle_pkg::STATUS_W-1:0]     status,
    output logic                              found,
    output logic [$clog2(DEPTH+1)-1:0]        length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = bsle_pkg::DATA_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CP_WR  = 4'd1;
    localparam logic [3:0] S_SW_RD1 = 4'd2;
    localparam logic [3:0] S_SW_WR0 = 4'd3;
    localparam logic [3:0] S_SW_WR1 = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_MOVE   = 4'd6;
    localparam logic [3:0] S_INS    = 4'd7;

    logic [3:0]                   state_reg, state_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [bsle_pkg::FUNC_W-1:0]  op_reg, op_next;
    logic [DW-1:0]                key_reg, key_next;
    logic [DW-1:0]                val_reg, val_next;
    logic [DW-1:0]                tmp_reg, tmp_next;
    logic [CW-1:0]                pos_reg, pos_next;     // next position to read
    logic [CW-1:0]                bpos_reg, bpos_next;   // swap partner, copy target or anchor
    logic [CW-1:0]                cnt_reg, cnt_next;     // reads left in a shift
    logic                         pend_reg, pend_next;   // read issued last cycle
    logic [CW-1:0]                pdst_reg, pdst_next;   // position tied to that read
    logic                         out_valid_reg, out_valid_next;
    logic [bsle_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         found_reg, found_next;
    logic [CW-1:0]                length_reg, length_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic                          fin;
    logic [bsle_pkg::STATUS_W-1:0] fin_status;
    logic                          fin_found;
    logic                          in_acc;
    logic [AW-1:0]                 head_m1;
    logic                          full;

    // ring slot of a sequence position
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    bsle_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc   = in_valid && in_ready;
    assign head_m1  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign full     = (count_reg == CW'(DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        tmp_next    = tmp_reg;
        pos_next    = pos_reg;
        bpos_next   = bpos_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        pdst_next   = pdst_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = val_reg;
        ram_raddr   = head_reg;
        fin         = 1'b0;
        fin_status  = bsle_pkg::ST_DONE;
        fin_found   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = func;
                    case (func)
                        bsle_pkg::FN_INS_FRONT:
                        begin
                            fin = 1'b1;
                            if (full)
                            begin
                                fin_status = bsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = head_m1;
                                ram_wdata  = value;
                                head_next  = head_m1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bsle_pkg::FN_INS_END:
                        begin
                            fin = 1'b1;
                            if (full)
                            begin
                                fin_status = bsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot(head_reg, count_reg);
                                ram_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bsle_pkg::FN_DEL_FIRST:
                        begin
                            fin = 1'b1;
                            if (count_reg == '0)
                            begin
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                head_next  = slot(head_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        bsle_pkg::FN_DEL_LAST:
                        begin
                            fin = 1'b1;
                            if (count_reg == '0)
                            begin
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        bsle_pkg::FN_DEL_SECOND, bsle_pkg::FN_ROTATE:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                fin        = 1'b1;
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                bpos_next  = (func == bsle_pkg::FN_ROTATE) ? count_reg : CW'(1);
                                state_next = S_CP_WR;
                            end
                        end
                        bsle_pkg::FN_SWAP_FL, bsle_pkg::FN_SWAP_FS:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                fin        = 1'b1;
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                bpos_next  = (func == bsle_pkg::FN_SWAP_FS) ? CW'(1)
                                                                            : count_reg - CW'(1);
                                state_next = S_SW_RD1;
                            end
                        end
                        bsle_pkg::FN_SWAP_FBL:
                        begin
                            if (count_reg < CW'(3))
                            begin
                                fin        = 1'b1;
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                bpos_next  = count_reg - CW'(2);
                                state_next = S_SW_RD1;
                            end
                        end
                        bsle_pkg::FN_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                key_next   = value;
                                pos_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        bsle_pkg::FN_INS_BEFORE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                // the head is never compared
                                key_next   = anchor_value;
                                val_next   = value;
                                pos_next   = CW'(1);
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        bsle_pkg::FN_DEL_MID:
                        begin
                            if (count_reg < CW'(3))
                            begin
                                fin        = 1'b1;
                                fin_status = bsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                // pull elements after the middle one step toward the head
                                pos_next   = (count_reg >> 1) + CW'(1);
                                cnt_next   = count_reg - CW'(1) - (count_reg >> 1);
                                pend_next  = 1'b0;
                                state_next = S_MOVE;
                            end
                        end
                        bsle_pkg::FN_CLEAR:
                        begin
                            fin        = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = bsle_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            S_CP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_reg, bpos_reg);
                ram_wdata = ram_rdata;
                head_next = slot(head_reg, CW'(1));
                if (op_reg == bsle_pkg::FN_DEL_SECOND)
                begin
                    count_next = count_reg - CW'(1);
                end
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_SW_RD1:
            begin
                ram_raddr  = slot(head_reg, bpos_reg);
                tmp_next   = ram_rdata;
                state_next = S_SW_WR0;
            end
            S_SW_WR0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = ram_rdata;
                state_next = S_SW_WR1;
            end
            S_SW_WR1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot(head_reg, bpos_reg);
                ram_wdata  = tmp_reg;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (pend_reg && (ram_rdata == key_reg))
                begin
                    pend_next = 1'b0;
                    if (op_reg == bsle_pkg::FN_SEARCH)
                    begin
                        fin        = 1'b1;
                        fin_found  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (full)
                    begin
                        fin        = 1'b1;
                        fin_found  = 1'b1;
                        fin_status = bsle_pkg::ST_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // open a gap at the anchor: push the tail one step back
                        bpos_next  = pdst_reg;
                        pos_next   = count_reg - CW'(1);
                        cnt_next   = count_reg - pdst_reg;
                        state_next = S_MOVE;
                    end
                end
                else if (pos_reg < count_reg)
                begin
                    ram_raddr = slot(head_reg, pos_reg);
                    pend_next = 1'b1;
                    pdst_next = pos_reg;
                    pos_next  = pos_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_MOVE:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(head_reg, pdst_reg);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg != '0)
                begin
                    ram_raddr = slot(head_reg, pos_reg);
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg - CW'(1);
                    if (op_reg == bsle_pkg::FN_DEL_MID)
                    begin
                        pdst_next = pos_reg - CW'(1);
                        pos_next  = pos_reg + CW'(1);
                    end
                    else
                    begin
                        pdst_next = pos_reg + CW'(1);
                        pos_next  = pos_reg - CW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (op_reg == bsle_pkg::FN_DEL_MID)
                        begin
                            count_next = count_reg - CW'(1);
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                end
            end
            S_INS:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot(head_reg, bpos_reg);
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
                fin_found  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        length_next    = length_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fin)
        begin
            out_valid_next = 1'b1;
            status_next    = fin_status;
            found_next     = fin_found;
            length_next    = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        tmp_reg    <= tmp_next;
        pos_reg    <= pos_next;
        bpos_reg   <= bpos_next;
        cnt_reg    <= cnt_next;
        pdst_reg   <= pdst_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        length_reg <= length_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign length    = length_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the bounded sequence list engine
module testbench;

    localparam int DEPTH     = 64;
    localparam int FW        = bsle_pkg::FUNC_W;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYCLE = 5000000;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [bsle_pkg::FUNC_W-1:0]        func;
    logic signed [bsle_pkg::DATA_W-1:0] value;
    logic signed [bsle_pkg::DATA_W-1:0] anchor_value;
    logic                               out_valid;
    logic                               out_ready;
    logic [bsle_pkg::STATUS_W-1:0]      status;
    logic                               found;
    logic [6:0]                         length;

    bounded_sequence_list_engine_top #(.DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .value(value), .anchor_value(anchor_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .length(length)
    );

    // one expected result item
    typedef struct packed {
        logic [bsle_pkg::STATUS_W-1:0] status;
        logic                          found;
        logic [6:0]                    length;
    } outcome_t;

    // one directed stimulus row; chk set means the typed expectation is compared too
    typedef struct {
        logic [bsle_pkg::FUNC_W-1:0] fn;
        logic [31:0]                 val;
        logic [31:0]                 anc;
        bit                          chk;
        outcome_t                    exp;
    } row_t;

    // shadow copy of the list, kept as a plain ordered array (position 0 is the head)
    logic [31:0] seq_mirror [0:DEPTH-1];
    int          seq_len = 0;
    outcome_t    pending_outcomes [$];
    int          errors = 0;
    int          n_results = 0;
    int          n_items = 0;
    int          cycle_count = 0;
    int          op_hits [0:15];
    bit          quiet_tail = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // free-running cycle count with a hard limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("%0t timeout with %0d results pending", $time, pending_outcomes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // compute the result of one request and update the shadow list
    function automatic outcome_t apply_request(logic [bsle_pkg::FUNC_W-1:0] fn, logic [31:0] v,
                                               logic [31:0] a);
        outcome_t    r;
        int          k;
        logic [31:0] t;
        r = '0;
        case (fn)
            bsle_pkg::FN_INS_FRONT, bsle_pkg::FN_INS_END:
                if (seq_len >= DEPTH) r.status = bsle_pkg::ST_FULL;
                else if (fn == bsle_pkg::FN_INS_FRONT)
                begin
                    for (int i = seq_len; i > 0; i--) seq_mirror[i] = seq_mirror[i-1];
                    seq_mirror[0] = v;
                    seq_len++;
                end
                else
                begin
                    seq_mirror[seq_len] = v;
                    seq_len++;
                end
            bsle_pkg::FN_DEL_FIRST:
                if (seq_len < 1) r.status = bsle_pkg::ST_IGNORED;
                else
                begin
                    for (int i = 0; i < seq_len - 1; i++) seq_mirror[i] = seq_mirror[i+1];
                    seq_len--;
                end
            bsle_pkg::FN_DEL_SECOND:
                if (seq_len < 2) r.status = bsle_pkg::ST_IGNORED;
                else
                begin
                    for (int i = 1; i < seq_len - 1; i++) seq_mirror[i] = seq_mirror[i+1];
                    seq_len--;
                end
            bsle_pkg::FN_DEL_LAST:
                if (seq_len < 1) r.status = bsle_pkg::ST_IGNORED;
                else seq_len--;
            bsle_pkg::FN_DEL_MID:
                if (seq_len < 3) r.status = bsle_pkg::ST_IGNORED;
                else
                begin
                    for (int i = seq_len / 2; i < seq_len - 1; i++)
                        seq_mirror[i] = seq_mirror[i+1];
                    seq_len--;
                end
            bsle_pkg::FN_SWAP_FL, bsle_pkg::FN_SWAP_FS, bsle_pkg::FN_SWAP_FBL:
            begin
                k = (fn == bsle_pkg::FN_SWAP_FL) ? seq_len - 1
                  : (fn == bsle_pkg::FN_SWAP_FS) ? 1 : seq_len - 2;
                if (seq_len < ((fn == bsle_pkg::FN_SWAP_FBL) ? 3 : 2))
                    r.status = bsle_pkg::ST_IGNORED;
                else
                begin
                    t = seq_mirror[0];
                    seq_mirror[0] = seq_mirror[k];
                    seq_mirror[k] = t;
                end
            end
            bsle_pkg::FN_SEARCH:
                for (int i = 0; i < seq_len; i++)
                    if (seq_mirror[i] == v) r.found = 1'b1;
            bsle_pkg::FN_ROTATE:
                if (seq_len < 2) r.status = bsle_pkg::ST_IGNORED;
                else
                begin
                    t = seq_mirror[0];
                    for (int i = 0; i < seq_len - 1; i++) seq_mirror[i] = seq_mirror[i+1];
                    seq_mirror[seq_len-1] = t;
                end
            bsle_pkg::FN_INS_BEFORE:
                if (seq_len < 1) r.status = bsle_pkg::ST_IGNORED;
                else
                begin
                    // head is never compared against the anchor
                    k = 0;
                    for (int i = 1; i < seq_len; i++)
                        if (k == 0 && seq_mirror[i] == a) k = i;
                    if (k != 0)
                    begin
                        r.found = 1'b1;
                        if (seq_len >= DEPTH) r.status = bsle_pkg::ST_FULL;
                        else
                        begin
                            for (int i = seq_len; i > k; i--) seq_mirror[i] = seq_mirror[i-1];
                            seq_mirror[k] = v;
                            seq_len++;
                        end
                    end
                end
            bsle_pkg::FN_CLEAR:
                seq_len = 0;
            default:
                r.status = bsle_pkg::ST_IGNORED;
        endcase
        r.length = seq_len[6:0];
        return r;
    endfunction

    // result side: random stall bursts until the quiet tail, compare at the rising edge
    initial
    begin
        int burst;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 15) == 0)
            begin
                burst = $urandom_range(1, 19);
                out_ready = 1'b0;
                repeat (burst) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual st=%0d f=%0d len=%0d",
                         $time, status, found, length);
                errors++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (status !== e.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time, e.status, status);
                    errors++;
                end
                if (found !== e.found)
                begin
                    $display("%0t found: expected %0d actual %0d", $time, e.found, found);
                    errors++;
                end
                if (length !== e.length)
                begin
                    $display("%0t length: expected %0d actual %0d", $time, e.length, length);
                    errors++;
                end
            end
        end
    end

    // present one item at the falling edge and hold it until it is taken
    task automatic send_item(logic [bsle_pkg::FUNC_W-1:0] fn, logic [31:0] v, logic [31:0] a);
        int burst;
        if (!quiet_tail && $urandom_range(0, 11) == 0)
        begin
            burst = $urandom_range(1, 19);
            in_valid = 1'b0;
            repeat (burst) @(negedge clk);
        end
        in_valid     = 1'b1;
        func         = fn;
        value        = v;
        anchor_value = a;
        pending_outcomes.push_back(apply_request(fn, v, a));
        op_hits[fn]++;
        n_items++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // values drawn from a small pool so that searches and anchors hit often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff0}
                            + $urandom_range(0, 15);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    // directed rows: empty-list refusals, extremes, every operation
    row_t directed [$];

    initial
    begin
        row_t r;
        logic [bsle_pkg::FUNC_W-1:0] fn;
        int fill;

        rst_n = 1'b0; in_valid = 1'b0; func = '0; value = '0; anchor_value = '0;
        foreach (op_hits[i]) op_hits[i] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list after reset: ignored with length zero; a search is done, not found
        directed.push_back('{bsle_pkg::FN_DEL_FIRST, 0, 0, 1,
                             '{bsle_pkg::ST_IGNORED, 1'b0, 7'd0}});
        directed.push_back('{bsle_pkg::FN_DEL_LAST, 0, 0, 1,
                             '{bsle_pkg::ST_IGNORED, 1'b0, 7'd0}});
        directed.push_back('{bsle_pkg::FN_ROTATE, 0, 0, 1,
                             '{bsle_pkg::ST_IGNORED, 1'b0, 7'd0}});
        directed.push_back('{bsle_pkg::FN_INS_BEFORE, 5, 5, 1,
                             '{bsle_pkg::ST_IGNORED, 1'b0, 7'd0}});
        directed.push_back('{bsle_pkg::FN_SEARCH, 0, 0, 1,
                             '{bsle_pkg::ST_DONE, 1'b0, 7'd0}});
        directed.push_back('{4'd13, 0, 0, 1, '{bsle_pkg::ST_IGNORED, 1'b0, 7'd0}});
        directed.push_back('{4'd15, 32'hffff_ffff, 32'hffff_ffff, 1,
                             '{bsle_pkg::ST_IGNORED, 1'b0, 7'd0}});
        directed.push_back('{bsle_pkg::FN_INS_END, 32'h8000_0000, 0, 1,
                             '{bsle_pkg::ST_DONE, 1'b0, 7'd1}});
        directed.push_back('{bsle_pkg::FN_INS_BEFORE, 1, 32'h8000_0000, 1,
                             '{bsle_pkg::ST_DONE, 1'b0, 7'd1}});
        directed.push_back('{bsle_pkg::FN_INS_FRONT, 32'h7fff_ffff, 0, 1,
                             '{bsle_pkg::ST_DONE, 1'b0, 7'd2}});
        directed.push_back('{bsle_pkg::FN_INS_END, 32'hffff_ffff, 0, 1,
                             '{bsle_pkg::ST_DONE, 1'b0, 7'd3}});
        directed.push_back('{bsle_pkg::FN_SEARCH, 32'h8000_0000, 0, 1,
                             '{bsle_pkg::ST_DONE, 1'b1, 7'd3}});
        directed.push_back('{bsle_pkg::FN_INS_BEFORE, 32'h1234_5678, 32'hffff_ffff, 1,
                             '{bsle_pkg::ST_DONE, 1'b1, 7'd4}});
        directed.push_back('{bsle_pkg::FN_SWAP_FL,    0, 0, 0, '0});
        directed.push_back('{bsle_pkg::FN_SWAP_FS,    0, 0, 0, '0});
        directed.push_back('{bsle_pkg::FN_SWAP_FBL,   0, 0, 0, '0});
        directed.push_back('{bsle_pkg::FN_ROTATE,     0, 0, 0, '0});
        directed.push_back('{bsle_pkg::FN_DEL_MID,    0, 0, 0, '0});
        directed.push_back('{bsle_pkg::FN_DEL_SECOND, 0, 0, 0, '0});
        directed.push_back('{bsle_pkg::FN_CLEAR, 0, 0, 1,
                             '{bsle_pkg::ST_DONE, 1'b0, 7'd0}});

        foreach (directed[i])
        begin
            r = directed[i];
            send_item(r.fn, r.val, r.anc);
            if (r.chk && pending_outcomes[$] !== r.exp)
            begin
                $display("%0t row %0d: expected %h, actual prediction %h",
                         $time, i, r.exp, pending_outcomes[$]);
                errors++;
            end
        end

        // fill to the limit, then refusals when full, a search, a middle delete and a clear
        for (int i = 0; i < DEPTH; i++) send_item(bsle_pkg::FN_INS_END, i, 0);
        send_item(bsle_pkg::FN_INS_FRONT, 1, 0);
        send_item(bsle_pkg::FN_INS_END, 1, 0);
        send_item(bsle_pkg::FN_INS_BEFORE, 9, 5);
        send_item(bsle_pkg::FN_SEARCH, 63, 0);
        send_item(bsle_pkg::FN_DEL_MID, 0, 0);
        send_item(bsle_pkg::FN_CLEAR, 0, 0);

        // random part, with fill bursts so the list gets deep and occasionally full
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                // hold off until the engine has drained every result
                in_valid = 1'b0;
                while (pending_outcomes.size() != 0) @(negedge clk);
            end
            if (n >= N_RANDOM - 200) quiet_tail = 1'b1;
            if ($urandom_range(0, 99) < 3)
            begin
                fill = $urandom_range(4, 70);
                for (int j = 0; j < fill; j++)
                    send_item($urandom_range(0, 1) ? bsle_pkg::FN_INS_END
                                                   : bsle_pkg::FN_INS_FRONT,
                              pick_value(), 0);
            end
            case ($urandom_range(0, 19))
                0, 1, 2: fn = bsle_pkg::FN_INS_END;
                3, 4:    fn = bsle_pkg::FN_INS_FRONT;
                5:       fn = FW'($urandom_range(13, 15));
                6:       fn = ($urandom_range(0, 5) == 0) ? bsle_pkg::FN_CLEAR
                                                          : bsle_pkg::FN_SEARCH;
                7, 8:    fn = bsle_pkg::FN_INS_BEFORE;
                default: fn = FW'($urandom_range(2, 11));
            endcase
            send_item(fn, pick_value(), pick_value());
        end

        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("ran %0d items, %0d results; ins_before %0d, search %0d, del_mid %0d, clear %0d",
                 n_items, n_results, op_hits[bsle_pkg::FN_INS_BEFORE],
                 op_hits[bsle_pkg::FN_SEARCH], op_hits[bsle_pkg::FN_DEL_MID],
                 op_hits[bsle_pkg::FN_CLEAR]);
        $display("covered empty, full and partly filled lists, unused codes and random stalls");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/bsle_pkg.sv
hw/rtl/bsle_ram.sv
hw/rtl/bounded_sequence_list_engine_top.sv
tb/testbench.sv
